// ===== design/ccrt_pkg.sv =====
// ccrt_pkg: types, codes and constants shared by the command retry tracker.
// No dependencies; imported by ccrt_step and the tracker core.
`timescale 1ns / 1ps
`default_nettype none

package ccrt_pkg;

   // Event kinds carried on one transaction
   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_FRAME   = 2'd1,
      OP_SENT    = 2'd2,
      OP_UNUSED  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      EV_NONE        = 3'd0,
      EV_SUCCESS     = 3'd1,
      EV_HW_ERROR    = 3'd2,
      EV_INVALID     = 3'd3,
      EV_UNKNOWN     = 3'd4,
      EV_NO_RESPONSE = 3'd5
   } event_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_RESPONSE_TIMEOUT  = 2'd0,
      CSR_RETRY_LIMIT       = 2'd1,
      CSR_HEARTBEAT_TIMEOUT = 2'd2,
      CSR_RESERVED          = 2'd3
   } csr_index_type;

   localparam logic [10:0] ID_HEARTBEAT    = 11'h000;
   localparam logic [10:0] ID_VALVE_CMD    = 11'h200;
   localparam logic [10:0] ID_OUTPUT_CMD   = 11'h201;
   localparam logic [10:0] ID_INTERVAL_CMD = 11'h400;
   localparam logic [10:0] ID_VALVE_RESP   = 11'h300;
   localparam logic [10:0] ID_SHARED_RESP  = 11'h301;

   localparam int VALVE_COUNT  = 8;
   localparam int OUTPUT_COUNT = 3;

   localparam logic [7:0] VALVE_BITS  = 8'((1 << VALVE_COUNT) - 1);
   localparam logic [2:0] OUTPUT_BITS = 3'(((1 << OUTPUT_COUNT) - 1) & 7);

   localparam logic [15:0] AGE_MAX   = 16'hFFFF;
   localparam logic [15:0] TIMER_MAX = 16'hFFFF;

   localparam logic [15:0] RESET_RESPONSE_TIMEOUT  = 16'd1000;
   localparam logic [3:0]  RESET_RETRY_LIMIT       = 4'd3;
   localparam logic [15:0] RESET_HEARTBEAT_TIMEOUT = 16'd15000;

   typedef struct packed {
      logic [15:0] response_timeout;
      logic [3:0]  retry_limit;
      logic [15:0] heartbeat_timeout;
   } cfg_type;

   typedef struct packed {
      logic        pending;
      logic [10:0] pending_id;
      logic [63:0] pending_data;
      logic [3:0]  retries_done;
      logic [15:0] response_timer;
      logic [15:0] heartbeat_age;
      logic        heartbeat_seen;
      logic        online;
      logic [7:0]  valve_cmd;
      logic [7:0]  valve_act;
      logic [2:0]  output_cmd;
      logic [2:0]  output_act;
      logic [7:0]  status_state;
      logic [7:0]  status_errors;
      logic [15:0] uptime;
   } state_type;

   typedef struct packed {
      logic      resend;
      event_type evt;
   } step_type;

   function automatic event_type status_event(input logic [7:0] st);
      event_type ev;
      case (st)
         8'd0:    ev = EV_SUCCESS;
         8'd1:    ev = EV_HW_ERROR;
         8'd2:    ev = EV_INVALID;
         default: ev = EV_UNKNOWN;
      endcase
      return ev;
   endfunction

endpackage

`default_nettype wire

// ===== design/can_command_retry_and_response_tracker_core.sv =====
// Top level of the CAN command retry and response tracker.
// Depends on ccrt_pkg and ccrt_step.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    op, frame_id, frame_len, frame_data
//   rsp      out        rsp_valid/rsp_ready    resend, event, valve/output bits, peer status
//   csr      in         csr_valid/csr_ready    csr_index, csr_wdata
//
// One transaction per cycle: state and the result register update on the accepting edge,
// so the result appears in the cycle after acceptance and the next item may follow at once.
// A held result blocks req only while rsp_ready is low (single output register).
// Reset clears all tracker state and loads the default timeouts; csr is always ready.
`timescale 1ns / 1ps
`default_nettype none

module can_command_retry_and_response_tracker_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [10:0] req_frame_id,
   input  logic [3:0]  req_frame_len,
   input  logic [63:0] req_frame_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_resend_valid,
   output logic [10:0] rsp_resend_id,
   output logic [63:0] rsp_resend_data,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_valves_commanded,
   output logic [7:0]  rsp_valves_actual,
   output logic [2:0]  rsp_outputs_commanded,
   output logic [2:0]  rsp_outputs_actual,
   output logic        rsp_peer_online,
   output logic [7:0]  rsp_peer_state,
   output logic [7:0]  rsp_peer_error_flags,
   output logic [15:0] rsp_peer_uptime,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import ccrt_pkg::*;

   cfg_type   cfg_ff;
   state_type state_ff;
   state_type state_in;
   step_type  step;
   logic      accept;

   logic        rsp_valid_ff;
   logic        resend_ff;
   logic [10:0] resend_id_ff;
   logic [63:0] resend_data_ff;
   event_type   event_ff;
   state_type   snap_ff;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.response_timeout  <= RESET_RESPONSE_TIMEOUT;
         cfg_ff.retry_limit       <= RESET_RETRY_LIMIT;
         cfg_ff.heartbeat_timeout <= RESET_HEARTBEAT_TIMEOUT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_RESPONSE_TIMEOUT:  cfg_ff.response_timeout  <= csr_wdata;
            CSR_RETRY_LIMIT:       cfg_ff.retry_limit       <= csr_wdata[3:0];
            CSR_HEARTBEAT_TIMEOUT: cfg_ff.heartbeat_timeout <= csr_wdata;
            default: ;
         endcase
      end
   end

   ccrt_step u_step (
      .cfg        (cfg_ff),
      .cur        (state_ff),
      .op         (req_op),
      .frame_id   (req_frame_id),
      .frame_len  (req_frame_len),
      .frame_data (req_frame_data),
      .nxt        (state_in),
      .res        (step)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         resend_ff      <= step.resend;
         resend_id_ff   <= step.resend ? state_in.pending_id : '0;
         resend_data_ff <= step.resend ? state_in.pending_data : '0;
         event_ff       <= step.evt;
         snap_ff        <= state_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_resend_valid      = resend_ff;
   assign rsp_resend_id         = resend_id_ff;
   assign rsp_resend_data       = resend_data_ff;
   assign rsp_event_res         = event_ff;
   assign rsp_valves_commanded  = snap_ff.valve_cmd;
   assign rsp_valves_actual     = snap_ff.valve_act;
   assign rsp_outputs_commanded = snap_ff.output_cmd;
   assign rsp_outputs_actual    = snap_ff.output_act;
   assign rsp_peer_online       = snap_ff.online;
   assign rsp_peer_state        = snap_ff.status_state;
   assign rsp_peer_error_flags  = snap_ff.status_errors;
   assign rsp_peer_uptime       = snap_ff.uptime;

   // idle tracker carries no retry count or running timer
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !state_ff.pending |-> (state_ff.retries_done == '0) && (state_ff.response_timer == '0))
      else $error("retry state left over without a pending command");

   a_online_seen: assert property (@(posedge clock) disable iff (reset)
      state_ff.online |-> state_ff.heartbeat_seen)
      else $error("peer online without any heartbeat");

   a_resend_no_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && resend_ff |-> (event_ff == EV_NONE))
      else $error("resend and event in one result");

   a_resend_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !resend_ff |-> (resend_id_ff == '0) && (resend_data_ff == '0))
      else $error("resend payload not cleared");

   a_resend_pending: assert property (@(posedge clock) disable iff (reset)
      accept && step.resend |=> state_ff.pending && (state_ff.response_timer == '0))
      else $error("resend without a restarted pending command");

endmodule

`default_nettype wire

// ===== design/ccrt_step.sv =====
// ccrt_step: next-state and event logic for one tick, received frame or sent command.
// Purely combinational; depends on ccrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccrt_step (
   input  ccrt_pkg::cfg_type   cfg,
   input  ccrt_pkg::state_type cur,
   input  logic [1:0]          op,
   input  logic [10:0]         frame_id,
   input  logic [3:0]          frame_len,
   input  logic [63:0]         frame_data,
   output ccrt_pkg::state_type nxt,
   output ccrt_pkg::step_type  res
);
   import ccrt_pkg::*;

   logic [7:0]  b0;
   logic [7:0]  b1;
   logic        len_ge2;
   logic        len_full;
   logic [15:0] timer_inc;
   logic [3:0]  retries_inc;
   logic [15:0] age_inc;
   logic [7:0]  vmask;
   logic [2:0]  omask;
   logic        track;

   assign b0       = frame_data[7:0];
   assign b1       = frame_data[15:8];
   // lengths above eight count as eight
   assign len_ge2  = (frame_len >= 4'd2);
   assign len_full = (frame_len >= 4'd8);
   assign timer_inc   = (cur.response_timer < TIMER_MAX) ? cur.response_timer + 16'd1
                                                         : cur.response_timer;
   assign retries_inc = cur.retries_done + 4'd1;
   assign age_inc     = (cur.heartbeat_age < AGE_MAX) ? cur.heartbeat_age + 16'd1
                                                      : cur.heartbeat_age;
   assign vmask = b0 & VALVE_BITS;
   assign omask = b0[2:0] & OUTPUT_BITS;

   always_comb begin
      nxt     = cur;
      res.resend = 1'b0;
      res.evt    = EV_NONE;
      track   = 1'b0;
      case (op)
         OP_TICK: begin
            if (cur.pending) begin
               nxt.response_timer = timer_inc;
               if (timer_inc >= cfg.response_timeout) begin
                  nxt.retries_done   = retries_inc;
                  nxt.response_timer = '0;
                  if (retries_inc < cfg.retry_limit) begin
                     res.resend = 1'b1;
                  end else begin
                     res.evt          = EV_NO_RESPONSE;
                     nxt.pending      = 1'b0;
                     nxt.retries_done = '0;
                  end
               end
            end
            nxt.heartbeat_age = age_inc;
            nxt.online = cur.heartbeat_seen && (age_inc <= cfg.heartbeat_timeout);
         end
         OP_FRAME: begin
            if (frame_id == ID_HEARTBEAT) begin
               if (len_ge2) begin
                  nxt.uptime         = {b1, b0};
                  nxt.heartbeat_age  = '0;
                  nxt.heartbeat_seen = 1'b1;
                  nxt.online         = 1'b1;
               end
            end else if (frame_id == ID_VALVE_RESP) begin
               if (len_ge2) begin
                  nxt.pending        = 1'b0;
                  nxt.retries_done   = '0;
                  nxt.response_timer = '0;
                  res.evt            = status_event(b1);
                  if (b1 == 8'd0) begin
                     nxt.valve_act = b0;
                  end
               end
            end else if (frame_id == ID_SHARED_RESP) begin
               // full-length frame with a small first byte is a status frame
               if (len_full && (b0 <= 8'd3)) begin
                  nxt.status_state  = b0;
                  nxt.status_errors = b1;
                  nxt.uptime        = frame_data[39:24];
               end else if (len_ge2) begin
                  nxt.pending        = 1'b0;
                  nxt.retries_done   = '0;
                  nxt.response_timer = '0;
                  res.evt            = status_event(b1);
                  if (b1 == 8'd0) begin
                     nxt.output_act = b0[2:0];
                  end
               end
            end
         end
         OP_SENT: begin
            if (frame_id == ID_VALVE_CMD) begin
               nxt.valve_cmd = (cur.valve_cmd & ~vmask) | (b1 & vmask);
               track = 1'b1;
            end else if (frame_id == ID_OUTPUT_CMD) begin
               nxt.output_cmd = (cur.output_cmd & ~omask) | (b1[2:0] & omask);
               track = 1'b1;
            end else if (frame_id == ID_INTERVAL_CMD) begin
               track = 1'b1;
            end
            if (track) begin
               nxt.pending        = 1'b1;
               nxt.pending_id     = frame_id;
               nxt.pending_data   = frame_data;
               nxt.retries_done   = '0;
               nxt.response_timer = '0;
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== dv/ccrt_tracker_checker.sv =====
// Scoreboard for the CAN command retry and response tracker core.
// Watches the req, csr and rsp channels, predicts every result and counts mismatches.
// Depends on ccrt_pkg.
`timescale 1ns / 1ps

module ccrt_tracker_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [10:0] req_frame_id,
   input  logic [3:0]  req_frame_len,
   input  logic [63:0] req_frame_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_resend_valid,
   input  logic [10:0] rsp_resend_id,
   input  logic [63:0] rsp_resend_data,
   input  logic [2:0]  rsp_event_res,
   input  logic [7:0]  rsp_valves_commanded,
   input  logic [7:0]  rsp_valves_actual,
   input  logic [2:0]  rsp_outputs_commanded,
   input  logic [2:0]  rsp_outputs_actual,
   input  logic        rsp_peer_online,
   input  logic [7:0]  rsp_peer_state,
   input  logic [7:0]  rsp_peer_error_flags,
   input  logic [15:0] rsp_peer_uptime,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          outstanding
);
   import ccrt_pkg::*;

   // status byte of a response frame
   localparam logic [7:0] STATUS_OK        = 8'd0;
   localparam logic [7:0] STATUS_HW_FAULT  = 8'd1;
   localparam logic [7:0] STATUS_BAD_CMD   = 8'd2;
   // highest first byte that still marks a full-length 0x301 frame as a status frame
   localparam logic [7:0] STATUS_STATE_MAX = 8'd3;
   localparam logic [3:0] MAX_LEN          = 4'd8;
   localparam logic [3:0] MIN_LEN          = 4'd2;

   typedef struct packed {
      logic        resend;
      logic [10:0] resend_id;
      logic [63:0] resend_data;
      logic [2:0]  evt;
      logic [7:0]  valves_cmd;
      logic [7:0]  valves_act;
      logic [2:0]  outputs_cmd;
      logic [2:0]  outputs_act;
      logic        online;
      logic [7:0]  peer_state;
      logic [7:0]  peer_errors;
      logic [15:0] peer_uptime;
   } tracker_result_type;

   tracker_result_type expected_results[$];

   logic [15:0] cfg_resp_timeout;
   logic [3:0]  cfg_retry_limit;
   logic [15:0] cfg_hb_timeout;

   logic        cmd_pending;
   logic [10:0] cmd_id;
   logic [63:0] cmd_data;
   logic [3:0]  retry_count;
   logic [15:0] wait_timer;
   logic [15:0] hb_age;
   logic        hb_seen;
   logic        peer_up;
   logic [7:0]  valve_cmd;
   logic [7:0]  valve_act;
   logic [2:0]  output_cmd;
   logic [2:0]  output_act;
   logic [7:0]  status_state;
   logic [7:0]  status_errors;
   logic [15:0] uptime;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   task automatic report_failure(input string msg);
      $display("ERROR %0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_failure($sformatf("%s: got %0h, expected %0h", name, got, want));
   endtask

   function automatic event_type status_to_event(input logic [7:0] status);
      if (status == STATUS_OK)       return EV_SUCCESS;
      if (status == STATUS_HW_FAULT) return EV_HW_ERROR;
      if (status == STATUS_BAD_CMD)  return EV_INVALID;
      return EV_UNKNOWN;
   endfunction

   // Advance the tracker by one event transaction and return what it should report.
   task automatic track_transaction(input logic [1:0] op, input logic [10:0] id,
                                    input logic [3:0] len_field, input logic [63:0] data,
                                    output tracker_result_type res);
      logic [3:0] len;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] mask;
      logic       fire;
      logic       track;
      event_type  evt;
      len   = (len_field > MAX_LEN) ? MAX_LEN : len_field;
      b0    = data[7:0];
      b1    = data[15:8];
      fire  = 1'b0;
      track = 1'b0;
      evt   = EV_NONE;
      case (op)
         OP_TICK: begin
            if (cmd_pending) begin
               if (wait_timer != TIMER_MAX) wait_timer = wait_timer + 16'd1;
               if (wait_timer >= cfg_resp_timeout) begin
                  retry_count = retry_count + 4'd1;
                  if (retry_count < cfg_retry_limit) begin
                     fire       = 1'b1;
                     wait_timer = '0;
                  end else begin
                     evt         = EV_NO_RESPONSE;
                     cmd_pending = 1'b0;
                     retry_count = '0;
                     wait_timer  = '0;
                  end
               end
            end
            if (hb_age != AGE_MAX) hb_age = hb_age + 16'd1;
            peer_up = hb_seen && (hb_age <= cfg_hb_timeout);
         end
         OP_FRAME: begin
            if (id == ID_HEARTBEAT) begin
               if (len >= MIN_LEN) begin
                  uptime  = {b1, b0};
                  hb_age  = '0;
                  hb_seen = 1'b1;
                  peer_up = 1'b1;
               end
            end else if (id == ID_VALVE_RESP) begin
               if (len >= MIN_LEN) begin
                  cmd_pending = 1'b0;
                  retry_count = '0;
                  wait_timer  = '0;
                  evt         = status_to_event(b1);
                  if (b1 == STATUS_OK) valve_act = b0;
               end
            end else if (id == ID_SHARED_RESP) begin
               if (len == MAX_LEN && b0 <= STATUS_STATE_MAX) begin
                  status_state  = b0;
                  status_errors = b1;
                  uptime        = data[39:24];
               end else if (len >= MIN_LEN) begin
                  cmd_pending = 1'b0;
                  retry_count = '0;
                  wait_timer  = '0;
                  evt         = status_to_event(b1);
                  if (b1 == STATUS_OK) output_act = b0[2:0];
               end
            end
         end
         OP_SENT: begin
            if (id == ID_VALVE_CMD) begin
               mask      = b0 & VALVE_BITS;
               valve_cmd = (valve_cmd & ~mask) | (b1 & mask);
               track     = 1'b1;
            end else if (id == ID_OUTPUT_CMD) begin
               mask       = b0 & {5'd0, OUTPUT_BITS};
               output_cmd = (output_cmd & ~mask[2:0]) | (b1[2:0] & mask[2:0]);
               track      = 1'b1;
            end else if (id == ID_INTERVAL_CMD) begin
               track = 1'b1;
            end
            if (track) begin
               cmd_pending = 1'b1;
               cmd_id      = id;
               cmd_data    = data;
               retry_count = '0;
               wait_timer  = '0;
            end
         end
         default: ;
      endcase
      res.resend      = fire;
      res.resend_id   = fire ? cmd_id : '0;
      res.resend_data = fire ? cmd_data : '0;
      res.evt         = evt;
      res.valves_cmd  = valve_cmd;
      res.valves_act  = valve_act;
      res.outputs_cmd = output_cmd;
      res.outputs_act = output_act;
      res.online      = peer_up;
      res.peer_state  = status_state;
      res.peer_errors = status_errors;
      res.peer_uptime = uptime;
   endtask

   task automatic compare_result(input tracker_result_type want);
      check_field("resend_valid", rsp_resend_valid, want.resend);
      check_field("resend_id", rsp_resend_id, want.resend_id);
      check_field("resend_data", rsp_resend_data, want.resend_data);
      check_field("event_res", rsp_event_res, want.evt);
      check_field("valves_commanded", rsp_valves_commanded, want.valves_cmd);
      check_field("valves_actual", rsp_valves_actual, want.valves_act);
      check_field("outputs_commanded", rsp_outputs_commanded, want.outputs_cmd);
      check_field("outputs_actual", rsp_outputs_actual, want.outputs_act);
      check_field("peer_online", rsp_peer_online, want.online);
      check_field("peer_state", rsp_peer_state, want.peer_state);
      check_field("peer_error_flags", rsp_peer_error_flags, want.peer_errors);
      check_field("peer_uptime", rsp_peer_uptime, want.peer_uptime);
   endtask

   always @(posedge clock) begin : monitor
      tracker_result_type want;
      if (reset) begin
         cfg_resp_timeout = RESET_RESPONSE_TIMEOUT;
         cfg_retry_limit  = RESET_RETRY_LIMIT;
         cfg_hb_timeout   = RESET_HEARTBEAT_TIMEOUT;
         cmd_pending      = 1'b0;
         cmd_id           = '0;
         cmd_data         = '0;
         retry_count      = '0;
         wait_timer       = '0;
         hb_age           = '0;
         hb_seen          = 1'b0;
         peer_up          = 1'b0;
         valve_cmd        = '0;
         valve_act        = '0;
         output_cmd       = '0;
         output_act       = '0;
         status_state     = '0;
         status_errors    = '0;
         uptime           = '0;
         expected_results.delete();
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RESPONSE_TIMEOUT:  cfg_resp_timeout = csr_wdata;
               CSR_RETRY_LIMIT:       cfg_retry_limit  = csr_wdata[3:0];
               CSR_HEARTBEAT_TIMEOUT: cfg_hb_timeout   = csr_wdata;
               default: ;
            endcase
         end
         // a result always belongs to an older transaction, so retire before predicting
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_failure("result transaction with no prediction waiting");
            end else begin
               want = expected_results.pop_front();
               compare_result(want);
            end
         end
         if (req_valid && req_ready) begin
            track_transaction(req_op, req_frame_id, req_frame_len, req_frame_data, want);
            expected_results.push_back(want);
         end
         outstanding <= expected_results.size();
      end
   end

endmodule

// ===== dv/tb_can_command_retry_and_response_tracker_core.sv =====
// Testbench top for the CAN command retry and response tracker core.
// Drives directed and random event transactions under several timeout settings and
// gives the verdict; depends on ccrt_pkg, the core and ccrt_tracker_checker.
`timescale 1ns / 1ps

module tb_can_command_retry_and_response_tracker_core;
   import ccrt_pkg::*;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op         = '0;
   logic [10:0] req_frame_id   = '0;
   logic [3:0]  req_frame_len  = '0;
   logic [63:0] req_frame_data = '0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic        rsp_resend_valid;
   logic [10:0] rsp_resend_id;
   logic [63:0] rsp_resend_data;
   logic [2:0]  rsp_event_res;
   logic [7:0]  rsp_valves_commanded;
   logic [7:0]  rsp_valves_actual;
   logic [2:0]  rsp_outputs_commanded;
   logic [2:0]  rsp_outputs_actual;
   logic        rsp_peer_online;
   logic [7:0]  rsp_peer_state;
   logic [7:0]  rsp_peer_error_flags;
   logic [15:0] rsp_peer_uptime;
   logic        csr_valid      = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index      = '0;
   logic [15:0] csr_wdata      = '0;

   int fail_count;
   int outstanding;
   int items_sent = 0;
   int req_quiet  = 0;
   int rsp_quiet  = 0;

   can_command_retry_and_response_tracker_core u_dut (.*);
   ccrt_tracker_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Gap before the next transaction; now and then a stretch with no gaps at all.
   task automatic draw_gap(inout int quiet_left, output int gap);
      if (quiet_left > 0) begin
         quiet_left--;
         gap = 0;
      end else if ($urandom_range(0, 19) == 0) begin
         quiet_left = $urandom_range(10, 50);
         gap = 0;
      end else begin
         gap = $urandom_range(0, 13);
      end
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // mostly lengths that the frame kinds accept, sometimes anything the field holds
   function automatic logic [3:0] frame_len_draw();
      if ($urandom_range(0, 7) == 0) return 4'($urandom_range(0, 15));
      return 4'($urandom_range(2, 8));
   endfunction

   initial begin : rsp_side
      int gap;
      forever begin
         draw_gap(rsp_quiet, gap);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   task automatic send_item(input op_type op, input logic [10:0] id, input logic [3:0] len,
                            input logic [63:0] data);
      int gap;
      draw_gap(req_quiet, gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_frame_id   <= id;
      req_frame_len  <= len;
      req_frame_data <= data;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_tick();
      send_item(OP_TICK, 11'($urandom), 4'($urandom), rand_word());
   endtask

   task automatic send_response();
      logic [63:0] data;
      logic [3:0]  len;
      int          pick;
      data = rand_word();
      pick = $urandom_range(0, 5);
      if (pick < 5) data[15:8] = (pick < 2) ? 8'd0 : 8'(pick - 1);
      len = frame_len_draw();
      if ($urandom_range(0, 1)) begin
         send_item(OP_FRAME, ID_VALVE_RESP, len, data);
      end else begin
         // half of the 0x301 traffic shaped as status frames
         if ($urandom_range(0, 1)) begin
            data[7:0] = 8'($urandom_range(0, 3));
            len = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15)) : 4'd8;
         end
         send_item(OP_FRAME, ID_SHARED_RESP, len, data);
      end
   endtask

   task automatic csr_put(input csr_index_type idx, input logic [15:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_settings(input logic [15:0] resp, input logic [3:0] limit,
                                 input logic [15:0] hb);
      csr_valid <= 1'b1;
      csr_put(CSR_RESPONSE_TIMEOUT, resp);
      csr_put(CSR_RETRY_LIMIT, {12'($urandom), limit});
      csr_put(CSR_HEARTBEAT_TIMEOUT, hb);
      csr_put(CSR_RESERVED, 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Stop sending and wait until every predicted result has been returned.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic run_phase(input logic [15:0] resp, input logic [3:0] limit,
                            input logic [15:0] hb, input int count);
      int          first;
      int          pick;
      int          span;
      logic [10:0] id;
      first = items_sent;
      write_settings(resp, limit, hb);
      while (items_sent - first < count) begin
         pick = $urandom_range(0, 19);
         if (pick < 8) begin
            // command, a random run of ticks that may reach the give-up point, maybe a reply
            pick = $urandom_range(0, 9);
            if (pick < 4)      id = ID_VALVE_CMD;
            else if (pick < 7) id = ID_OUTPUT_CMD;
            else if (pick < 9) id = ID_INTERVAL_CMD;
            else               id = 11'($urandom);
            send_item(OP_SENT, id, frame_len_draw(), rand_word());
            span = (int'(resp) + 1) * (int'(limit) + 1) + 2;
            if (span > 40) span = 40;
            repeat ($urandom_range(0, span)) send_tick();
            if ($urandom_range(0, 1)) send_response();
         end else if (pick < 11) begin
            send_item(OP_FRAME, ID_HEARTBEAT, frame_len_draw(), rand_word());
            span = int'(hb) + 3;
            if (span > 40) span = 40;
            repeat ($urandom_range(0, span)) send_tick();
         end else if (pick < 15) begin
            send_item(op_type'($urandom_range(0, 3)), 11'($urandom), 4'($urandom),
                      rand_word());
         end else begin
            send_response();
         end
      end
      drain();
   endtask

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed transactions under the reset settings
      send_item(OP_TICK, ID_HEARTBEAT, 4'd0, 64'd0);
      send_item(OP_FRAME, ID_HEARTBEAT, 4'd2, 64'h0000_0000_0000_BEEF);
      send_item(OP_FRAME, ID_HEARTBEAT, 4'd1, 64'h0000_0000_0000_1234);
      send_item(OP_SENT, ID_VALVE_CMD, 4'd2, 64'h0000_0000_0000_A5FF);
      send_item(OP_SENT, ID_OUTPUT_CMD, 4'd2, 64'h0000_0000_0000_FFFF);
      send_item(OP_SENT, ID_INTERVAL_CMD, 4'd8, '1);
      send_item(OP_SENT, 11'h123, 4'd8, 64'h0000_0000_0000_FFFF);
      send_item(OP_FRAME, ID_VALVE_RESP, 4'd2, 64'h0000_0000_0000_003C);
      send_item(OP_FRAME, ID_VALVE_RESP, 4'd8, 64'h0000_0000_0000_01FF);
      send_item(OP_FRAME, ID_VALVE_RESP, 4'd2, 64'h0000_0000_0000_0200);
      send_item(OP_FRAME, ID_VALVE_RESP, 4'd15, '1);
      send_item(OP_FRAME, ID_VALVE_RESP, 4'd1, 64'd0);
      send_item(OP_FRAME, ID_SHARED_RESP, 4'd8, 64'h0000_00CD_AB00_5A03);
      send_item(OP_FRAME, ID_SHARED_RESP, 4'd8, 64'h0000_0000_0000_0004);
      send_item(OP_FRAME, ID_SHARED_RESP, 4'd7, 64'h0000_0000_0000_0003);
      send_item(OP_FRAME, ID_SHARED_RESP, 4'd12, 64'hFFFF_FFFF_FF01_7702);
      send_item(OP_FRAME, ID_SHARED_RESP, 4'd1, 64'd0);
      send_item(OP_FRAME, ID_SHARED_RESP, 4'd3, 64'h0000_0000_0000_02FF);
      send_item(OP_UNUSED, 11'h7FF, 4'hF, '1);
      send_item(OP_FRAME, 11'h7FF, 4'hF, '1);
      send_item(OP_SENT, ID_VALVE_CMD, 4'd0, 64'd0);
      send_tick();
      send_tick();
      send_item(OP_FRAME, ID_HEARTBEAT, 4'hF, '1);
      drain();

      run_phase(16'd3, 4'd3, 16'd20, 130);
      // zero timeout fires on the first tick, zero limit gives up at the first timeout
      run_phase(16'd0, 4'd0, 16'd0, 120);
      run_phase(16'd1, 4'd15, 16'd1, 140);
      run_phase(16'hFFFF, 4'd1, 16'hFFFF, 100);
      run_phase(16'd5, 4'd2, 16'd8, 140);
      run_phase(16'd1, 4'd1, 16'd3, 120);
      run_phase(16'd4, 4'd8, 16'd12, 100);
      run_phase(16'($urandom_range(1, 8)), 4'($urandom_range(1, 6)),
                16'($urandom_range(2, 40)), 130);
      run_phase(16'($urandom_range(1, 8)), 4'($urandom_range(1, 6)),
                16'($urandom_range(2, 40)), 130);

      repeat (4) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
